// ===== hw/rtl/tcsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsb_pkg
// Shared constants, types and codes of the text console scroll buffer.
// ----------------------------------------------------------------------------
package tcsb_pkg;

  // grid geometry
  localparam int unsigned MAX_COLS  = 128;
  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned TAB_WIDTH = 2;

  localparam int unsigned STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned COL_W  = $clog2(MAX_COLS + 1);     // holds a width up to MAX_COLS
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS + 1);     // holds a row count up to MAX_ROWS
  localparam int unsigned RING_W = $clog2(MAX_ROWS);         // ring start row
  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);  // cell counts and offsets
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);      // cell store address
  localparam int unsigned TABC_W = $clog2(TAB_WIDTH + 1);    // prints left for one item

  // fixed field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned OUT_COL_W = 7;
  localparam int unsigned OUT_ROW_W = 6;
  localparam int unsigned CFG_LW_W  = 8;
  localparam int unsigned CFG_LC_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd1;

  localparam logic [CFG_LW_W-1:0] LINE_WIDTH_RST = 8'd127;
  localparam logic [CFG_LC_W-1:0] LINE_COUNT_RST = 7'd47;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  // result kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_REDRAW = 1'b1;

  typedef enum logic [1:0] {
    CH_PRINT,
    CH_BS,
    CH_TAB,
    CH_NL
  } tcsb_char_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PCHK,
    ST_PWRAP,
    ST_PSTORE,
    ST_NL,
    ST_NLWRAP,
    ST_BS
  } tcsb_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming character
    logic row_inc;    // cursor moves down one row
    logic scroll;     // ring start advances one row
    logic store;      // write the cell at the fill point and bump the fill count
    logic pad;        // stored cell is a space
    logic bs;         // remove the last cell
    logic emit;       // load the output register
    logic emit_kind;
    logic emit_last;
  } tcsb_cmd_t;

  // datapath to controller
  typedef struct packed {
    tcsb_char_e char_class;
    logic       col_full;
    logic       row_past_end;
    logic       fill_zero;
    logic       out_free;
  } tcsb_stat_t;

endpackage

// ===== hw/rtl/tcsb_ram.sv =====
// ----------------------------------------------------------------------------
// tcsb_ram
// Generic single port RAM with registered read data, no reset.
// ----------------------------------------------------------------------------
module tcsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write, and registered read of the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hw/rtl/tcsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcsb_ctrl
// Sequencer: decodes each character and steps the datapath through the
// wrap, scroll, store and padding steps, one step a cycle; a step that emits waits while the result register is full.
// ----------------------------------------------------------------------------
module tcsb_ctrl import tcsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tcsb_stat_t stat_i,
  output tcsb_cmd_t  cmd_o
);

  tcsb_state_e             state_q, state_d;
  logic [TABC_W-1:0]       prints_q, prints_d;
  logic                    accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prints_q <= '0;
    end else begin
      state_q  <= state_d;
      prints_q <= prints_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    prints_d   = prints_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (stat_i.char_class)
            CH_BS:  state_d = ST_BS;
            CH_NL:  state_d = ST_NL;
            CH_TAB: begin
              prints_d = TABC_W'(TAB_WIDTH);
              state_d  = ST_PCHK;
            end
            default: begin
              prints_d = TABC_W'(1);
              state_d  = ST_PCHK;
            end
          endcase
        end
      end
      // deferred wrap: move down only once the row is full
      ST_PCHK: begin
        if (stat_i.col_full) begin
          cmd_o.row_inc = 1'b1;
          state_d       = ST_PWRAP;
        end else begin
          state_d = ST_PSTORE;
        end
      end
      ST_PWRAP: begin
        if (!stat_i.row_past_end) begin
          state_d = ST_PSTORE;
        end else if (stat_i.out_free) begin
          cmd_o.scroll    = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_REDRAW;
          cmd_o.emit_last = 1'b0;
          state_d         = ST_PSTORE;
        end
      end
      ST_PSTORE: begin
        if (stat_i.out_free) begin
          cmd_o.store     = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_DRAW;
          cmd_o.emit_last = (prints_q == TABC_W'(1));
          prints_d        = prints_q - TABC_W'(1);
          state_d         = (prints_q == TABC_W'(1)) ? ST_IDLE : ST_PCHK;
        end
      end
      // newline: pad the row one cell a cycle
      ST_NL: begin
        if (stat_i.col_full) begin
          cmd_o.row_inc = 1'b1;
          state_d       = ST_NLWRAP;
        end else begin
          cmd_o.store = 1'b1;
          cmd_o.pad   = 1'b1;
        end
      end
      ST_NLWRAP: begin
        if (!stat_i.row_past_end) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.scroll    = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_REDRAW;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_BS: begin
        if (stat_i.fill_zero) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.bs        = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_REDRAW;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/tcsb_dp.sv =====
// ----------------------------------------------------------------------------
// tcsb_dp
// Datapath: configuration, fill count, cursor and ring registers, cell
// address generation, cell store and the result register.
// ----------------------------------------------------------------------------
module tcsb_dp import tcsb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  tcsb_cmd_t            cmd_i,
  output tcsb_stat_t           stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 kind_o,
  output logic [OUT_COL_W-1:0] column_o,
  output logic [OUT_ROW_W-1:0] row_o,
  output logic [CHAR_W-1:0]    glyph_o,
  output logic                 last_o
);

  logic [CFG_LW_W-1:0] line_width_q;
  logic [CFG_LC_W-1:0] line_count_q;
  logic                cfg_clear;

  logic [COL_W-1:0]  w_eff;
  logic [ROW_W-1:0]  l_eff;
  logic [FILL_W-1:0] w_ext;
  logic [FILL_W-1:0] total_q;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [ROW_W-1:0]  cursor_q, cursor_d;
  logic [RING_W-1:0] ring_q, ring_d;
  logic [FILL_W-1:0] row_base_q, row_base_d;
  logic [FILL_W-1:0] ring_base_q, ring_base_d;
  logic [CHAR_W-1:0] glyph_q;

  logic [FILL_W-1:0] col;
  logic [FILL_W:0]   addr_sum;
  logic [FILL_W:0]   addr_mod;
  logic [ROW_W-1:0]  ring_next;
  logic [CHAR_W-1:0] cell_data;

  // configuration registers, a write to either register restarts the grid
  assign cfg_clear = cfg_we_i &&
                     (cfg_index_i == CFG_LINE_WIDTH || cfg_index_i == CFG_LINE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_count_q <= LINE_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_LINE_WIDTH) begin
        line_width_q <= cfg_wdata_i[CFG_LW_W-1:0];
      end
      if (cfg_index_i == CFG_LINE_COUNT) begin
        line_count_q <= cfg_wdata_i[CFG_LC_W-1:0];
      end
    end
  end

  // clamped geometry
  always_comb begin
    if (COL_W'(line_width_q) < COL_W'(2)) begin
      w_eff = COL_W'(2);
    end else if (COL_W'(line_width_q) > COL_W'(MAX_COLS)) begin
      w_eff = COL_W'(MAX_COLS);
    end else begin
      w_eff = COL_W'(line_width_q);
    end
    if (ROW_W'(line_count_q) < ROW_W'(2)) begin
      l_eff = ROW_W'(2);
    end else if (ROW_W'(line_count_q) > ROW_W'(MAX_ROWS)) begin
      l_eff = ROW_W'(MAX_ROWS);
    end else begin
      l_eff = ROW_W'(line_count_q);
    end
  end

  assign w_ext = FILL_W'(w_eff);

  // grid size, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    total_q <= w_ext * FILL_W'(l_eff);
  end

  // cursor column and cell address
  assign col       = (fill_q >= row_base_q) ? (fill_q - row_base_q) : '0;
  assign addr_sum  = {1'b0, fill_q} + {1'b0, ring_base_q};
  assign addr_mod  = (addr_sum >= {1'b0, total_q}) ? (addr_sum - {1'b0, total_q}) : addr_sum;
  assign ring_next = ROW_W'(ring_q) + ROW_W'(1);
  assign cell_data = cmd_i.pad ? CHAR_SPACE : glyph_q;

  // status to the controller
  always_comb begin
    if (char_code_i == CHAR_LF || char_code_i == CHAR_CR) begin
      stat_o.char_class = CH_NL;
    end else if (char_code_i == CHAR_BS) begin
      stat_o.char_class = CH_BS;
    end else if (char_code_i == CHAR_TAB) begin
      stat_o.char_class = CH_TAB;
    end else begin
      stat_o.char_class = CH_PRINT;
    end
    stat_o.col_full     = (col >= w_ext);
    stat_o.row_past_end = (cursor_q >= l_eff);
    stat_o.fill_zero    = (fill_q == '0);
    stat_o.out_free     = !out_valid_o || out_ready_i;
  end

  // next values of the grid position registers
  always_comb begin
    fill_d      = fill_q;
    cursor_d    = cursor_q;
    ring_d      = ring_q;
    row_base_d  = row_base_q;
    ring_base_d = ring_base_q;
    priority if (cfg_clear) begin
      fill_d      = '0;
      cursor_d    = '0;
      ring_d      = '0;
      row_base_d  = '0;
      ring_base_d = '0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (cmd_i.row_inc) begin
      cursor_d   = cursor_q + ROW_W'(1);
      row_base_d = row_base_q + w_ext;
    end else if (cmd_i.scroll) begin
      if (cursor_q != '0) begin
        cursor_d   = cursor_q - ROW_W'(1);
        row_base_d = row_base_q - w_ext;
      end
      if (ring_next >= l_eff) begin
        ring_d      = '0;
        ring_base_d = '0;
      end else begin
        ring_d      = ring_next[RING_W-1:0];
        ring_base_d = ring_base_q + w_ext;
      end
      fill_d = (fill_q >= w_ext) ? (fill_q - w_ext) : '0;
    end else if (cmd_i.bs) begin
      fill_d = fill_q - FILL_W'(1);
      // removing a cell from an empty row moves the cursor up
      if (cursor_q != '0 && fill_q <= row_base_q) begin
        cursor_d   = cursor_q - ROW_W'(1);
        row_base_d = row_base_q - w_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cursor_q    <= '0;
      ring_q      <= '0;
      row_base_q  <= '0;
      ring_base_q <= '0;
    end else begin
      fill_q      <= fill_d;
      cursor_q    <= cursor_d;
      ring_q      <= ring_d;
      row_base_q  <= row_base_d;
      ring_base_q <= ring_base_d;
    end
  end

  // character latch, tab prints spaces
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      glyph_q <= (char_code_i == CHAR_TAB) ? CHAR_SPACE : char_code_i;
    end
  end

  // cell store
  tcsb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .addr_i  (addr_mod[ADDR_W-1:0]),
    .wdata_i (cell_data),
    .rdata_o ()
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o <= cmd_i.emit_kind;
      last_o <= cmd_i.emit_last;
      if (cmd_i.emit_kind == KIND_REDRAW) begin
        column_o <= '0;
        row_o    <= '0;
        glyph_o  <= '0;
      end else begin
        column_o <= col[OUT_COL_W-1:0];
        row_o    <= cursor_q[OUT_ROW_W-1:0];
        glyph_o  <= glyph_q;
      end
    end
  end

endmodule

// ===== hw/rtl/text_console_scroll_buffer.sv =====
// Order: a draw result is registered from the store state, after the check state and,
// on a wrap, the wrap state; a backspace redraw from the backspace state; a newline redraw from its wrap state.
// A new character is taken only once the last one is done; a newline stores its padding
// cells one at a time, set by the one cell store write port.
// Reset: asynchronous, clears the grid position and registers to width 127, 47 rows;
// the cell store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// text_console_scroll_buffer
// Ring-ordered character grid with deferred wrap, scrolling and draw results.
// ----------------------------------------------------------------------------
module text_console_scroll_buffer import tcsb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CHAR_W-1:0]    char_code_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 kind_o,
  output logic [OUT_COL_W-1:0] column_o,
  output logic [OUT_ROW_W-1:0] row_o,
  output logic [CHAR_W-1:0]    glyph_o,
  output logic                 last_o
);

  tcsb_cmd_t  cmd;
  tcsb_stat_t stat;

  // sequencer
  tcsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  tcsb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_code_i (char_code_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .column_o    (column_o),
    .row_o       (row_o),
    .glyph_o     (glyph_o),
    .last_o      (last_o)
  );

endmodule

// ===== hw/rtl/tcsb_checker.sv =====
// ----------------------------------------------------------------------------
// tcsb_checker
// Port level assertions for the text console scroll buffer.
// ----------------------------------------------------------------------------
module tcsb_checker import tcsb_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [CHAR_W-1:0]    char_code_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 kind_o,
  input logic [OUT_COL_W-1:0] column_o,
  input logic [OUT_ROW_W-1:0] row_o,
  input logic [CHAR_W-1:0]    glyph_o,
  input logic                 last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({kind_o, column_o, row_o, glyph_o, last_o}))
    else $error("result beat changed while stalled");

  // a redraw carries no position or glyph
  a_redraw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REDRAW |->
      column_o == '0 && row_o == '0 && glyph_o == '0)
    else $error("redraw with nonzero fields");

  // one character at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  // a scroll redraw that is not the last beat is followed at once by its draw
  a_redraw_then_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KIND_REDRAW && !last_o |=>
      out_valid_o && kind_o == KIND_DRAW)
    else $error("redraw not followed by its draw");

endmodule

bind text_console_scroll_buffer tcsb_checker u_tcsb_checker (.*);
